@@ hw/rtl/tps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for the tertile pivot selector
// Sizes of the sorting chain, command struct for the chain, controller
// states and the constant divide-by-three helper.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int MAX_ITEMS = 512;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VAL_W     = 32;
  localparam int LIM_W     = 10;
  localparam int CMP_W     = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SORT_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT = 2'd1;

  // reciprocal of three, exact for inputs below 2**CNT_W
  localparam int DIV3_SH = CNT_W + 1;
  localparam logic [DIV3_SH-1:0] DIV3_MUL = DIV3_SH'((2 ** DIV3_SH + 2) / 3);

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [IDX_W-1:0]        index_t;

  // one command to every cell of the chain per cycle
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } chain_cmd_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_POS,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // floor(x / 3) by multiply and shift
  function automatic count_t div3(input count_t x);
    logic [CNT_W+DIV3_SH-1:0] prod;
    prod = {{DIV3_SH{1'b0}}, x} * {{CNT_W{1'b0}}, DIV3_MUL};
    return prod[CNT_W+DIV3_SH-1:DIV3_SH];
  endfunction

endpackage

@@ hw/rtl/tps_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_cell: one slot of the insertion sorting chain
// Holds one value and its valid bit. On insert it keeps its value, takes
// the new value, or takes its left neighbor's value; on shift it takes
// its right neighbor's value; on clear it drops its value.
// ----------------------------------------------------------------------------
module tps_cell (
  input  logic                clk,
  input  logic                rst,
  input  tps_pkg::chain_cmd_t cmd,
  input  tps_pkg::value_t     new_val,
  input  tps_pkg::value_t     left_val,
  input  logic                left_vld,
  input  logic                left_after,
  input  tps_pkg::value_t     right_val,
  input  logic                right_vld,
  output tps_pkg::value_t     val,
  output logic                vld,
  output logic                after
);
  import tps_pkg::*;

  // this slot lies at or beyond the insertion point of the new value
  assign after = !vld || (val > new_val);

  // update the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (cmd.clear) begin
      vld <= 1'b0;
    end else if (cmd.shift) begin
      vld <= right_vld;
    end else if (cmd.insert && after) begin
      vld <= left_after ? left_vld : 1'b1;
    end
  end

  // update the stored value
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      val <= right_val;
    end else if (cmd.insert && after) begin
      val <= left_after ? left_val : new_val;
    end
  end

endmodule

@@ hw/rtl/tps_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_chain: row of sorting cells
// Keeps the values of a set in ascending order, smallest in cell zero.
// The head cell is read out while the row shifts toward it.
// ----------------------------------------------------------------------------
module tps_chain (
  input  logic                clk,
  input  logic                rst,
  input  tps_pkg::chain_cmd_t cmd,
  input  tps_pkg::value_t     new_val,
  output tps_pkg::value_t     head_val
);
  import tps_pkg::*;

  value_t cell_val   [MAX_ITEMS];
  logic   cell_vld   [MAX_ITEMS];
  logic   cell_after [MAX_ITEMS];

  // build the row, each cell wired to both neighbors
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    value_t lval;
    logic   lvld;
    logic   lafter;
    value_t rval;
    logic   rvld;

    if (i == 0) begin : g_head
      assign lval   = '0;
      assign lvld   = 1'b0;
      assign lafter = 1'b0;
    end else begin : g_left
      assign lval   = cell_val[i-1];
      assign lvld   = cell_vld[i-1];
      assign lafter = cell_after[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_right
      assign rval = cell_val[i+1];
      assign rvld = cell_vld[i+1];
    end

    tps_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_val    (new_val),
      .left_val   (lval),
      .left_vld   (lvld),
      .left_after (lafter),
      .right_val  (rval),
      .right_vld  (rvld),
      .val        (cell_val[i]),
      .vld        (cell_vld[i]),
      .after      (cell_after[i])
    );
  end

  assign head_val = cell_val[0];

endmodule

@@ hw/rtl/tertile_pivot_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tertile_pivot_select: tertile pivots of a set of signed values
// Sorts a set as it streams in and reports the values at the one-third
// and two-thirds ranks once the set ends.
// ----------------------------------------------------------------------------
// Usage:
//   Values of a set arrive on the s_ channel, one request per cycle, the
//   final one with s_tlast high. Each value is placed in the sorting chain
//   in the cycle it is accepted, so a set loads at one value per cycle.
//   After the last value the block takes no input while it finds the
//   pivots: it works out the ranks, then the chain shifts toward its
//   head one cell per cycle until it passes the deeper rank r (r at most
//   341), then the result register loads once the output is free and
//   m_tvalid rises. A set at or below small_limit skips the shift.
//   s_tready returns together with m_tvalid. One result per set leaves
//   on the m_ channel. Values beyond 512 per set are dropped and flagged.
//   When the receiver stalls, the result holds in its output register; the
//   next set loads meanwhile, and the one after waits until the result is
//   taken. Reset empties the chain, clears m_tvalid and sets sort_order
//   to ascending and small_limit to 3. Write configuration only while idle.
// ----------------------------------------------------------------------------
module tertile_pivot_select (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tps_pkg::LIM_W-1:0]     cfg_data,
  // input values
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [31:0] value
  input  logic                          s_tlast,   // is_last
  // results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,   // [31:0] low_pivot, [63:32] high_pivot
  output logic [1:0]                    m_tuser    // [0] found, [1] overflow
);
  import tps_pkg::*;

  state_t     state;
  state_t     state_next;
  chain_cmd_t cmd;
  value_t     head_val;

  logic              sort_order;
  logic [LIM_W-1:0]  small_limit;
  count_t            count;
  logic              ovf;
  logic              found;
  index_t            idx_a;
  index_t            idx_b;
  index_t            idx_hi;
  index_t            step;
  value_t            piv_a;
  value_t            piv_b;

  logic   accept;
  logic   full;
  logic   out_free;
  logic   found_now;
  count_t ceil3;
  count_t floor3;
  count_t pos_a;
  count_t pos_b;
  count_t rnk_a;
  count_t rnk_b;

  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(MAX_ITEMS));
  assign out_free = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_order  <= 1'b0;
      small_limit <= LIM_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SORT_ORDER:  sort_order  <= cfg_data[0];
        REG_SMALL_LIMIT: small_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and chain commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        s_tready   = 1'b1;
        cmd.insert = accept && !full;
        if (accept && s_tlast) begin
          state_next = ST_POS;
        end
      end
      ST_POS: begin
        state_next = found_now ? ST_DRAIN : ST_EMIT;
      end
      ST_DRAIN: begin
        cmd.shift = 1'b1;
        if (step == idx_hi) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.clear  = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // ranks from the set size: ceil(n/3)-1 and ceil(n/3)+floor(n/3)-1
  assign ceil3  = div3(count + CNT_W'(2));
  assign floor3 = div3(count);
  assign pos_a  = ceil3 - CNT_W'(1);
  assign pos_b  = ceil3 + floor3 - CNT_W'(1);
  assign rnk_a  = sort_order ? (count - CNT_W'(1) - pos_a) : pos_a;
  assign rnk_b  = sort_order ? (count - CNT_W'(1) - pos_b) : pos_b;

  // pivots exist only for a set above the small-set limit
  assign found_now = (count != '0) && (CMP_W'(count) > CMP_W'(small_limit));

  // set size and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (state == ST_LOAD && accept) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // work out ranks, then pick the pivots off the head as the chain shifts
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (state == ST_POS) begin
      found <= found_now;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POS) begin
      idx_a  <= rnk_a[IDX_W-1:0];
      idx_b  <= rnk_b[IDX_W-1:0];
      idx_hi <= sort_order ? rnk_a[IDX_W-1:0] : rnk_b[IDX_W-1:0];
      step   <= '0;
      piv_a  <= '0;
      piv_b  <= '0;
    end else if (state == ST_DRAIN) begin
      step <= step + IDX_W'(1);
      if (step == idx_a) begin
        piv_a <= head_val;
      end
      if (step == idx_b) begin
        piv_b <= head_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {piv_b, piv_a};
      m_tuser <= {ovf, found};
    end
  end

  tps_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .new_val  (s_tdata),
    .head_val (head_val)
  );

endmodule

@@ hw/rtl/tps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_checker: port-level checks for the tertile pivot selector
// Watches the ports of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
module tps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [63:0]                   m_tdata,
  input logic [1:0]                    m_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // report zero pivots when the set was too small
  a_zero_pivots: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("pivots not zero on a result without pivots");

  // stop taking values once a set has ended
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after the end of a set");

  // come out of reset with no result pending
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind tertile_pivot_select tps_checker u_tps_checker (.*);
